>>> design/kpv_pkg.sv
// ----------------------------------------------------------------------------
// kpv_pkg
// Shared constants, types and helpers for the keyword presence vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kpv_pkg;

    // table geometry
    localparam int KW_NUM   = 64;                     // keyword lanes
    localparam int WORD_LEN = 16;                     // bytes per keyword
    localparam int RA_W     = $clog2(WORD_LEN);       // table row address
    localparam int WP_W     = $clog2(WORD_LEN + 2);   // word position, saturates at WORD_LEN+1

    // field widths
    localparam int CMD_W      = 2;
    localparam int KW_IDX_W   = 6;
    localparam int CHAR_POS_W = 4;
    localparam int CH_W       = 8;
    localparam int CNT_W      = 7;
    localparam int VEC_W      = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EOS  = 2'd2;

    // special characters
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

    // table write and read request
    typedef struct packed {
        logic                we;
        logic [KW_IDX_W-1:0] wlane;
        logic [RA_W-1:0]     wpos;
        logic [CH_W-1:0]     wdata;
        logic [RA_W-1:0]     raddr;
    } t_tbl_req;

    // per-lane compare result for the current word position
    typedef struct packed {
        logic [KW_NUM-1:0] miss;   // keyword char differs or keyword ended
        logic [KW_NUM-1:0] term;   // keyword ends at this position
    } t_tbl_rsp;

    // ascii lower case
    function automatic logic [CH_W-1:0] to_lower(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/kpv_ram.sv
// ----------------------------------------------------------------------------
// kpv_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
`default_nettype none

module kpv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, new data on same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && i_waddr == i_raddr) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/kpv_lanes.sv
// ----------------------------------------------------------------------------
// kpv_lanes
// Keyword table, one RAM per keyword lane, and the per-lane character compare.
// ----------------------------------------------------------------------------
`default_nettype none

module kpv_lanes (
    input  wire logic                     i_clk,
    input  wire kpv_pkg::t_tbl_req        i_req,
    input  wire logic [kpv_pkg::CH_W-1:0] i_ch,
    output kpv_pkg::t_tbl_rsp             o_rsp
);

    logic [kpv_pkg::CH_W-1:0] ch_lc;

    assign ch_lc = kpv_pkg::to_lower(i_ch);

    for (genvar k = 0; k < kpv_pkg::KW_NUM; k++) begin : g_lane
        logic                     lane_we;
        logic [kpv_pkg::CH_W-1:0] kc;

        assign lane_we = i_req.we && (i_req.wlane == kpv_pkg::KW_IDX_W'(k));

        kpv_ram #(
            .WIDTH (kpv_pkg::CH_W),
            .DEPTH (kpv_pkg::WORD_LEN)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (lane_we),
            .i_waddr (i_req.wpos),
            .i_wdata (i_req.wdata),
            .i_raddr (i_req.raddr),
            .o_rdata (kc)
        );

        // keyword char at the current word position vs. text char
        assign o_rsp.term[k] = (kc == kpv_pkg::CH_NUL);
        assign o_rsp.miss[k] = (kc == kpv_pkg::CH_NUL) || (kpv_pkg::to_lower(kc) != ch_lc);
    end

endmodule

`default_nettype wire

>>> design/kpv_word.sv
// ----------------------------------------------------------------------------
// kpv_word
// Word tracking: position, open flag, surviving keywords and sentence presence.
// ----------------------------------------------------------------------------
`default_nettype none

module kpv_word (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [kpv_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [kpv_pkg::CH_W-1:0]    i_ch,
    input  wire kpv_pkg::t_tbl_rsp           i_rsp,
    input  wire logic [kpv_pkg::CNT_W-1:0]   i_keyword_count,
    output logic      [kpv_pkg::RA_W-1:0]    o_raddr,
    output logic      [kpv_pkg::KW_NUM-1:0]  o_found
);

    logic [kpv_pkg::WP_W-1:0]   r_word_pos, n_word_pos;
    logic                       r_in_word, n_in_word;
    logic [kpv_pkg::KW_NUM-1:0] r_match, n_match;
    logic [kpv_pkg::KW_NUM-1:0] r_presence, n_presence;

    logic                       is_text, is_eos, ch_skip, ch_space, finish;
    logic                       len_full, word_ok;
    logic [kpv_pkg::KW_NUM-1:0] lane_on, cand, first;

    // command decode
    assign is_text  = i_step && (i_cmd == kpv_pkg::CMD_TEXT);
    assign is_eos   = i_step && (i_cmd == kpv_pkg::CMD_EOS);
    assign ch_skip  = (i_ch == kpv_pkg::CH_LF) || (i_ch == kpv_pkg::CH_CR);
    assign ch_space = (i_ch == kpv_pkg::CH_SPACE);
    assign finish   = is_eos || (is_text && ch_space);

    // lanes in use
    for (genvar k = 0; k < kpv_pkg::KW_NUM; k++) begin : g_on
        assign lane_on[k] = kpv_pkg::CNT_W'(k) < i_keyword_count;
    end

    // word end: lowest surviving keyword of equal length
    assign len_full = (r_word_pos == kpv_pkg::WP_W'(kpv_pkg::WORD_LEN));
    assign word_ok  = r_in_word && (r_word_pos <= kpv_pkg::WP_W'(kpv_pkg::WORD_LEN));
    assign cand     = (r_match & lane_on & (len_full ? '1 : i_rsp.term))
                      & {kpv_pkg::KW_NUM{word_ok}};
    assign first    = cand & (~cand + 1'b1);
    assign o_found  = r_presence | first;

    // next state
    always_comb begin
        n_word_pos = r_word_pos;
        n_in_word  = r_in_word;
        n_match    = r_match;
        n_presence = r_presence;
        if (finish) begin
            n_presence = is_eos ? '0 : o_found;
            n_word_pos = '0;
            n_in_word  = 1'b0;
            n_match    = '1;
        end else if (is_text && !ch_skip) begin
            n_in_word = 1'b1;
            if (r_word_pos < kpv_pkg::WP_W'(kpv_pkg::WORD_LEN)) begin
                n_match    = r_match & ~i_rsp.miss;
                n_word_pos = r_word_pos + 1'b1;
            end else begin
                n_match    = '0;
                n_word_pos = kpv_pkg::WP_W'(kpv_pkg::WORD_LEN + 1);
            end
        end
    end

    // table row read for the next item
    assign o_raddr = kpv_pkg::RA_W'(n_word_pos);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos <= '0;
            r_in_word  <= 1'b0;
            r_match    <= '1;
            r_presence <= '0;
        end else begin
            r_word_pos <= n_word_pos;
            r_in_word  <= n_in_word;
            r_match    <= n_match;
            r_presence <= n_presence;
        end
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_pos <= kpv_pkg::WP_W'(kpv_pkg::WORD_LEN + 1))
        else $error("word position out of range");

    a_open_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_word == (r_word_pos != '0))
        else $error("word open flag disagrees with position");

    a_closed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_word |-> (r_match == '1))
        else $error("match bits not reset between words");
`endif

endmodule

`default_nettype wire

>>> design/keyword_presence_vector_unit.sv
// ----------------------------------------------------------------------------
// keyword_presence_vector_unit
// Keyword table match of sentence words, emitting a presence vector per sentence.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | i_valid/o_ready, i_cmd, i_kw_index, i_char_pos, | in
//           | i_ch                                            |
//  output   | o_valid/i_ready, o_bow_vector                   | out
//  config   | i_cfg_we, i_cfg_wdata (keyword count)           | in
//
//  one word per cycle while no end of sentence is held; an item passes the input
//  register, end of sentence gives its vector in the output register next.
//  all 64 lane RAMs are read in parallel at the next word position.
//  reset clears control state only; the keyword table is not cleared.
//  an end-of-sentence word waits in the input register while the output
//  register is full and not taken; other words never stall.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_presence_vector_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [kpv_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [kpv_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [kpv_pkg::KW_IDX_W-1:0]     i_kw_index,
    input  wire logic [kpv_pkg::CHAR_POS_W-1:0]   i_char_pos,
    input  wire logic [kpv_pkg::CH_W-1:0]         i_ch,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [kpv_pkg::VEC_W-1:0]        o_bow_vector
);

    logic [kpv_pkg::CNT_W-1:0]      r_keyword_count;
    logic                           r_in_valid;
    logic [kpv_pkg::CMD_W-1:0]      r_cmd;
    logic [kpv_pkg::KW_IDX_W-1:0]   r_kw_index;
    logic [kpv_pkg::CHAR_POS_W-1:0] r_char_pos;
    logic [kpv_pkg::CH_W-1:0]       r_ch;
    logic                           r_out_valid;
    logic [kpv_pkg::VEC_W-1:0]      r_bow_vector;

    logic                           out_free, step, in_take;
    logic [kpv_pkg::RA_W-1:0]       raddr;
    logic [kpv_pkg::KW_NUM-1:0]     found;
    kpv_pkg::t_tbl_req              tbl_req;
    kpv_pkg::t_tbl_rsp              tbl_rsp;

    // handshake
    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && ((r_cmd != kpv_pkg::CMD_EOS) || out_free);
    assign o_ready  = !r_in_valid || step;
    assign in_take  = i_valid && o_ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyword_count <= '0;
        end else if (i_cfg_we) begin
            r_keyword_count <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd      <= i_cmd;
            r_kw_index <= i_kw_index;
            r_char_pos <= i_char_pos;
            r_ch       <= i_ch;
        end
    end

    // table access
    always_comb begin
        tbl_req.we    = step && (r_cmd == kpv_pkg::CMD_LOAD)
                        && (32'(r_kw_index) < kpv_pkg::KW_NUM)
                        && (32'(r_char_pos) < kpv_pkg::WORD_LEN);
        tbl_req.wlane = r_kw_index;
        tbl_req.wpos  = kpv_pkg::RA_W'(r_char_pos);
        tbl_req.wdata = r_ch;
        tbl_req.raddr = raddr;
    end

    kpv_lanes u_lanes (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .i_ch  (r_ch),
        .o_rsp (tbl_rsp)
    );

    kpv_word u_word (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_cmd           (r_cmd),
        .i_ch            (r_ch),
        .i_rsp           (tbl_rsp),
        .i_keyword_count (r_keyword_count),
        .o_raddr         (raddr),
        .o_found         (found)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_cmd == kpv_pkg::CMD_EOS) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_cmd == kpv_pkg::CMD_EOS) begin
            r_bow_vector <= kpv_pkg::VEC_W'(found);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bow_vector = r_bow_vector;

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_cmd == kpv_pkg::CMD_EOS && r_out_valid && !i_ready))
        else $error("input stalled without a blocked end of sentence");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid && r_cmd == kpv_pkg::CMD_EOS))
        else $error("result without an end of sentence");

    a_eos_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_cmd == kpv_pkg::CMD_EOS && out_free) |=> o_valid)
        else $error("end of sentence did not produce a result");
`endif

endmodule

`default_nettype wire

>>> sim/keyword_presence_vector_unit_tb.sv
// ----------------------------------------------------------------------------
// keyword_presence_vector_unit_tb
// Self-checking bench: loads the whole keyword table, runs a directed table of
// sentences and then random sentences under several keyword counts. A local
// bag-of-words matcher predicts every vector that no directed row fixes, and
// each vector taken is compared in order. Both handshakes idle at random, and
// the output side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_presence_vector_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kpv_pkg::*;

    localparam int CLK_HALF     = 1;
    localparam int DRAIN_CYCLES = 6;      // input reg + output reg, with margin
    localparam int SETTLE_LIMIT = 5000;
    localparam int HOLD_AT      = 15;     // vector count that starts the long hold-off
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASE_WORDS  = 160;
    localparam int MAX_REPORTS  = 10;

    // cmd code the unit ignores
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    // keyword alphabet: a b z A B Z and the bytes just outside both letter ranges
    localparam logic [CH_W-1:0] ALPHA [10] = '{8'h61, 8'h62, 8'h7A, 8'h41, 8'h42,
                                               8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B};

    // directed rows: plain word, run of text chars, or keyword count write
    typedef enum logic [1:0] {ROW_WORD, ROW_RUN, ROW_COUNT} t_row_kind;

    // run rows send kw consecutive text chars from ch; count rows write ch
    typedef struct packed {
        t_row_kind             kind;
        logic [CMD_W-1:0]      cmd;
        logic [KW_IDX_W-1:0]   kw;
        logic [CHAR_POS_W-1:0] pos;
        logic [CH_W-1:0]       ch;
        logic                  has_fixed;
        logic [VEC_W-1:0]      vec;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    t_dir_row directed_rows [DIR_ROWS] = '{
        // count still zero: nothing can match
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  "g",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  "o",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_EOS,     6'd0,  4'd0,  8'h00,    1'b1, 64'd0},
        '{ROW_COUNT, CMD_LOAD,    6'd0,  4'd0,  8'd127,   1'b0, 64'd0},
        // leading space, line ends inside the word, repeated spaces, duplicate keyword
        '{ROW_WORD,  CMD_TEXT,    6'd63, 4'd15, CH_SPACE, 1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  "G",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  CH_LF,    1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  "O",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  CH_CR,    1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  CH_SPACE, 1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  CH_SPACE, 1'b0, 64'd0},
        '{ROW_WORD,  CMD_EOS,     6'd63, 4'd15, 8'hFF,    1'b1, 64'h1},
        // empty sentence
        '{ROW_WORD,  CMD_EOS,     6'd0,  4'd0,  8'h00,    1'b1, 64'd0},
        // overlong word whose first 16 chars equal keyword 2
        '{ROW_RUN,   CMD_TEXT,    6'd17, 4'd0,  "A",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_EOS,     6'd0,  4'd0,  8'h00,    1'b1, 64'd0},
        // keyword 3 loaded while the sentence is open
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  "g",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  CH_SPACE, 1'b0, 64'd0},
        '{ROW_WORD,  CMD_LOAD,    6'd3,  4'd0,  "Q",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  "q",      1'b0, 64'd0},
        '{ROW_WORD,  CMD_EOS,     6'd0,  4'd0,  8'h00,    1'b1, 64'h8},
        // ignored command, load at the far corner of the table
        '{ROW_WORD,  CMD_IGNORED, 6'd63, 4'd15, 8'hFF,    1'b0, 64'd0},
        '{ROW_WORD,  CMD_LOAD,    6'd63, 4'd15, 8'hFF,    1'b0, 64'd0},
        // zero and all-ones text bytes
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  CH_NUL,   1'b0, 64'd0},
        '{ROW_WORD,  CMD_TEXT,    6'd0,  4'd0,  8'hFF,    1'b0, 64'd0},
        '{ROW_WORD,  CMD_EOS,     6'd0,  4'd0,  8'h00,    1'b0, 64'd0}
    };

    // dut signals
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      in_cmd      = '0;
    logic [KW_IDX_W-1:0]   in_kw_index = '0;
    logic [CHAR_POS_W-1:0] in_char_pos = '0;
    logic [CH_W-1:0]       in_ch       = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [VEC_W-1:0]      out_vector;

    // matcher state
    logic [CH_W-1:0]  kw_table [KW_NUM][WORD_LEN];
    int               word_pos;
    logic             in_word;
    logic [VEC_W-1:0] match_bits;
    logic [VEC_W-1:0] presence_bits;
    logic [CNT_W-1:0] kw_count;

    // scoreboard
    logic [VEC_W-1:0] expected_vecs [$];
    logic [VEC_W-1:0] want_vec;
    int               mismatches    = 0;
    int               vectors_taken = 0;
    int               words_sent    = 0;
    logic             fast_mode     = 1'b0;

    // receiver pacing
    int rx_seen = 0;
    int rx_gap  = 0;
    int rx_hold = 0;

    keyword_presence_vector_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_cmd        (in_cmd),
        .i_kw_index   (in_kw_index),
        .i_char_pos   (in_char_pos),
        .i_ch         (in_ch),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_bow_vector (out_vector)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // matcher
    // ------------------------------------------------------------------------

    function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    // word done: lowest still-matching keyword of equal length gets its bit
    function automatic void close_word();
        int   lanes;
        logic hit;
        lanes = (int'(kw_count) > KW_NUM) ? KW_NUM : int'(kw_count);
        hit   = 1'b0;
        if (in_word && word_pos <= WORD_LEN) begin
            for (int k = 0; k < lanes; k++) begin
                if (!hit && match_bits[k] &&
                    (word_pos == WORD_LEN || kw_table[k][word_pos] == CH_NUL)) begin
                    presence_bits[k] = 1'b1;
                    hit = 1'b1;
                end
            end
        end
        word_pos   = 0;
        in_word    = 1'b0;
        match_bits = '1;
    endfunction

    function automatic void take_char(input logic [CH_W-1:0] c);
        if (c == CH_LF || c == CH_CR) begin
            return;
        end
        if (c == CH_SPACE) begin
            close_word();
            return;
        end
        in_word = 1'b1;
        if (word_pos < WORD_LEN) begin
            for (int k = 0; k < KW_NUM; k++) begin
                if (kw_table[k][word_pos] == CH_NUL ||
                    fold_case(kw_table[k][word_pos]) != fold_case(c)) begin
                    match_bits[k] = 1'b0;
                end
            end
            word_pos++;
        end else begin
            match_bits = '0;
            word_pos   = WORD_LEN + 1;
        end
    endfunction

    // one accepted word; returns 1 with the vector on end of sentence
    function automatic logic advance_matcher(input logic [CMD_W-1:0]      cmd,
                                             input logic [KW_IDX_W-1:0]   kw,
                                             input logic [CHAR_POS_W-1:0] pos,
                                             input logic [CH_W-1:0]       c,
                                             output logic [VEC_W-1:0]     vec);
        vec = '0;
        case (cmd)
            CMD_LOAD: begin
                kw_table[kw][pos] = c;
            end
            CMD_TEXT: begin
                take_char(c);
            end
            CMD_EOS: begin
                close_word();
                vec           = presence_bits;
                presence_bits = '0;
                return 1'b1;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [CMD_W-1:0]      cmd,
                             input logic [KW_IDX_W-1:0]   kw,
                             input logic [CHAR_POS_W-1:0] pos,
                             input logic [CH_W-1:0]       c,
                             input logic                  has_fixed,
                             input logic [VEC_W-1:0]      fixed_vec);
        int               gap;
        logic [VEC_W-1:0] vec;
        gap = fast_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_cmd      <= cmd;
        in_kw_index <= kw;
        in_char_pos <= pos;
        in_ch       <= c;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (advance_matcher(cmd, kw, pos, c, vec)) begin
            expected_vecs.push_back(has_fixed ? fixed_vec : vec);
        end
        if (cmd != CMD_IGNORED) begin
            words_sent++;
        end
        @(negedge clk);
    endtask

    task automatic send_text(input logic [CH_W-1:0] c);
        send_word(CMD_TEXT, KW_IDX_W'($urandom), CHAR_POS_W'($urandom), c, 1'b0, '0);
    endtask

    // drop valid, wait for every vector, then let the pipeline empty
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_vecs.size() != 0 && waited < SETTLE_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (expected_vecs.size() != 0) begin
            flag_error($sformatf("%0d presence vectors never arrived",
                                 expected_vecs.size()));
            expected_vecs.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] count);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we    <= 1'b0;
        kw_count   = count;
    endtask

    // every table byte gets written before any text is compared
    task automatic fill_keyword_table();
        logic [CH_W-1:0] text [WORD_LEN];
        string           fixed_word;
        int              len;
        for (int lane = 0; lane < KW_NUM; lane++) begin
            foreach (text[i]) text[i] = CH_NUL;
            case (lane)
                0:       fixed_word = "go";
                1:       fixed_word = "GO";
                2:       fixed_word = "abcdefghijklmnop";
                default: fixed_word = "";
            endcase
            if (lane < 4) begin
                for (int i = 0; i < fixed_word.len(); i++) text[i] = fixed_word[i];
            end else begin
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = WORD_LEN;
                    default: len = $urandom_range(1, 4);
                endcase
                for (int i = 0; i < len; i++) text[i] = ALPHA[$urandom_range(0, 9)];
            end
            for (int pos = 0; pos < WORD_LEN; pos++) begin
                send_word(CMD_LOAD, KW_IDX_W'(lane), CHAR_POS_W'(pos), text[pos], 1'b0, '0);
            end
        end
    endtask

    // one text word: mostly a keyword in mixed case, else noise or near the limit
    task automatic send_random_word();
        logic [CH_W-1:0] chars [$];
        int              pick;
        int              lane;
        int              len;
        logic [CH_W-1:0] c;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            lane = $urandom_range(0, KW_NUM - 1);
            len  = 0;
            while (len < WORD_LEN && kw_table[lane][len] != CH_NUL) len++;
            for (int i = 0; i < len; i++) begin
                c = kw_table[lane][i];
                if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                    $urandom_range(0, 1) == 1) begin
                    c = c ^ 8'h20;
                end
                chars.push_back(c);
            end
        end else if (pick < 8) begin
            repeat ($urandom_range(1, 5)) chars.push_back(ALPHA[$urandom_range(0, 9)]);
        end else if (pick == 8) begin
            repeat ($urandom_range(1, 4)) chars.push_back(CH_W'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(WORD_LEN - 1, WORD_LEN + 2)) begin
                chars.push_back(ALPHA[$urandom_range(0, 9)]);
            end
        end
        if (chars.size() == 0) begin
            chars.push_back(ALPHA[0]);
        end
        foreach (chars[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                send_text(($urandom_range(0, 1) == 1) ? CH_LF : CH_CR);
            end
            send_text(chars[i]);
        end
    endtask

    // sentence with stray loads and ignored commands mixed in
    task automatic send_sentence();
        int words;
        words = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) begin
            send_text(CH_SPACE);
        end
        for (int w = 0; w < words; w++) begin
            if (w > 0) begin
                repeat ($urandom_range(1, 3)) send_text(CH_SPACE);
            end
            if ($urandom_range(0, 9) == 0) begin
                send_word(CMD_LOAD, KW_IDX_W'($urandom), CHAR_POS_W'($urandom),
                          ($urandom_range(0, 1) == 1) ? ALPHA[$urandom_range(0, 9)]
                                                      : CH_W'($urandom),
                          1'b0, '0);
            end
            if ($urandom_range(0, 14) == 0) begin
                send_word(CMD_IGNORED, KW_IDX_W'($urandom), CHAR_POS_W'($urandom),
                          CH_W'($urandom), 1'b0, '0);
            end
            send_random_word();
        end
        if ($urandom_range(0, 2) == 0) begin
            send_text(CH_SPACE);
        end
        send_word(CMD_EOS, KW_IDX_W'($urandom), CHAR_POS_W'($urandom), CH_W'($urandom),
                  1'b0, '0);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] count, input logic fast, input int n);
        int target;
        write_count(count);
        fast_mode = fast;
        target    = words_sent + n;
        while (words_sent < target) send_sentence();
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // ready pacing: fresh gap per taken vector, one long hold-off
    always @(negedge clk) begin
        if (vectors_taken != rx_seen) begin
            rx_seen = vectors_taken;
            rx_gap  = fast_mode ? 0 : $urandom_range(0, 12);
            if (rx_seen == HOLD_AT) begin
                rx_hold = HOLD_CYCLES;
            end
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            out_ready <= 1'b0;
            rx_hold--;
        end else if (rx_gap > 0) begin
            out_ready <= 1'b0;
            rx_gap--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // compare each taken vector with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_vecs.size() == 0) begin
                flag_error($sformatf("unexpected presence vector %h", out_vector));
            end else begin
                want_vec = expected_vecs.pop_front();
                if (out_vector !== want_vec) begin
                    flag_error($sformatf("presence vector: expected %h, got %h",
                                         want_vec, out_vector));
                end
            end
            vectors_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial begin
        word_pos      = 0;
        in_word       = 1'b0;
        match_bits    = '1;
        presence_bits = '0;
        kw_count      = '0;

        // synchronous reset, then release
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        write_count('0);
        fill_keyword_table();

        // directed table
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_COUNT: begin
                    write_count(CNT_W'(directed_rows[i].ch));
                end
                ROW_RUN: begin
                    for (int j = 0; j < int'(directed_rows[i].kw); j++) begin
                        send_text(CH_W'(directed_rows[i].ch + j));
                    end
                end
                default: begin
                    send_word(directed_rows[i].cmd, directed_rows[i].kw,
                              directed_rows[i].pos, directed_rows[i].ch,
                              directed_rows[i].has_fixed, directed_rows[i].vec);
                end
            endcase
        end

        // random sentences under several keyword counts
        run_phase(7'd64, 1'b0, PHASE_WORDS);
        run_phase(7'd1, 1'b1, PHASE_WORDS);
        run_phase(7'd127, 1'b0, PHASE_WORDS);
        run_phase(CNT_W'($urandom_range(2, 63)), 1'b0, PHASE_WORDS);
        run_phase(7'd65, 1'b1, PHASE_WORDS);

        settle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> keyword_presence_vector_unit.f
design/kpv_pkg.sv
design/kpv_ram.sv
design/kpv_lanes.sv
design/kpv_word.sv
design/keyword_presence_vector_unit.sv
sim/keyword_presence_vector_unit_tb.sv
